@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, a, b)
`define ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/pcte_pkg.sv @@
package pcte_pkg;
	localparam int MAX_KNOTS_DEF     = 256;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int DATA_W            = 32;
	localparam int CFG_W             = 9;

	// Register indexes of the configuration port.
	localparam logic REG_ORDER = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	// floor(y/6) = floor(((y + DIV_BIAS) >> 1) * DIV_RECIP >> 33) - DIV_BIAS/6
	localparam logic [33:0] DIV_BIAS   = 34'd2147483652;
	localparam logic [31:0] DIV_BIAS_Q = 32'd357913942;
	localparam logic [31:0] DIV_RECIP  = 32'hAAAAAAAB;

	typedef logic [2:0][DATA_W-1:0] coef_set_t;

	typedef struct packed {
		logic       start;
		logic [1:0] steps;
	} hr_ctl_t;

	typedef struct packed {
		logic done;
	} hr_stat_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (v > hi) return 32'sh7FFFFFFF;
		if (v < lo) return 32'sh80000000;
		return v[DATA_W-1:0];
	endfunction
endpackage

@@ rtl/pcte_knot_mem.sv @@
module pcte_knot_mem #(
	parameter int MAX_KNOTS = pcte_pkg::MAX_KNOTS_DEF,
	parameter int IDX_W     = $clog2(MAX_KNOTS)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [IDX_W-1:0]              waddr,
	input  logic [pcte_pkg::DATA_W-1:0]   wpos,
	input  logic [4*pcte_pkg::DATA_W-1:0] wder,
	input  logic [IDX_W-1:0]              raddr,
	output logic [pcte_pkg::DATA_W-1:0]   rpos,
	output logic [4*pcte_pkg::DATA_W-1:0] rder
);
	import pcte_pkg::*;

	logic [DATA_W-1:0]   pos_mem [MAX_KNOTS];
	logic [4*DATA_W-1:0] der_mem [MAX_KNOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			pos_mem[waddr] <= wpos;
			der_mem[waddr] <= wder;
		end
		rpos <= pos_mem[raddr];
		rder <= der_mem[raddr];
	end
endmodule

@@ rtl/pcte_horner.sv @@
module pcte_horner #(
	parameter int FRACTION_BITS = pcte_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pcte_pkg::hr_ctl_t                   ctl,
	input  logic signed [pcte_pkg::DATA_W-1:0]  d,
	input  logic signed [pcte_pkg::DATA_W-1:0]  acc_init,
	input  pcte_pkg::coef_set_t                 coef,
	output pcte_pkg::hr_stat_t                  stat,
	output logic signed [pcte_pkg::DATA_W-1:0]  result
);
	import pcte_pkg::*;

	typedef enum logic [1:0] {H_IDLE, H_MUL, H_ADD, H_DONE} hstate_t;

	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRACTION_BITS - 1);

	hstate_t            state_q;
	logic signed [31:0] d_q;
	logic signed [31:0] acc_q;
	coef_set_t          coef_q;
	logic [1:0]         step_q;
	logic [1:0]         steps_q;
	logic signed [63:0] prod_s1;
	logic signed [63:0] rnd;
	logic signed [63:0] sum;

	// Product rounded half up to the fraction, then the coefficient added.
	always_comb begin
		rnd = (prod_s1 + HALF) >>> FRACTION_BITS;
		sum = 64'(signed'(coef_q[step_q])) + rnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			step_q  <= '0;
			steps_q <= '0;
		end else begin
			unique case (state_q)
				H_IDLE: begin
					if (ctl.start) begin
						d_q     <= d;
						acc_q   <= acc_init;
						coef_q  <= coef;
						step_q  <= '0;
						steps_q <= ctl.steps;
						state_q <= (ctl.steps == 2'd0) ? H_DONE : H_MUL;
					end
				end
				H_MUL: begin
					prod_s1 <= d_q * acc_q;
					state_q <= H_ADD;
				end
				H_ADD: begin
					acc_q   <= sat32(sum);
					step_q  <= step_q + 2'd1;
					state_q <= (step_q + 2'd1 == steps_q) ? H_DONE : H_MUL;
				end
				H_DONE: begin
					state_q <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign stat.done = (state_q == H_DONE);
	assign result    = acc_q;
endmodule

@@ rtl/piecewise_cubic_taylor_eval.sv @@
// Piecewise cubic Taylor evaluator. A load item (action 0) writes one knot, its position
// and value, slope, curvature and third derivative, into a knot memory in the cycle it is
// accepted and gives no result; loads are taken back to back. A query item (action 1)
// gives one result: the knot interval of query_x is found by bisection over the first
// knot_count knots (increasing or decreasing order, clamped at both ends), then the
// Taylor cubic about that knot, or its derivative of order derivative_order, is evaluated
// by Horner's rule in signed Q16.16 with saturation at every stage; orders above three
// give zero. A query holds off every further item until it is finished, in these steps:
// the two end knots are read, then one memory read per bisection step on the single read
// port, then ST_DIFF takes the chosen knot and runs the reciprocal multiply for the
// third-derivative term, ST_PREP sets up the Horner chain, each Horner stage multiplies on
// one shared multiplier and then adds, the sum is handed back, and ST_DONE moves the result
// into the output register once it is free. Each lower order has one Horner stage less;
// orders above three skip the search and the Horner chain. The result sits in an output
// register, so the next item is taken while it waits. Knots must be written before a
// query reads them. The user must write configuration only while the block is idle; the
// block itself does not enforce this.
`include "assert_macros.svh"

module piecewise_cubic_taylor_eval #(
	parameter int MAX_KNOTS     = pcte_pkg::MAX_KNOTS_DEF,
	parameter int FRACTION_BITS = pcte_pkg::FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [pcte_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic [7:0]                         knot_slot,
	input  logic signed [pcte_pkg::DATA_W-1:0] knot_position,
	input  logic signed [pcte_pkg::DATA_W-1:0] knot_value,
	input  logic signed [pcte_pkg::DATA_W-1:0] knot_slope,
	input  logic signed [pcte_pkg::DATA_W-1:0] knot_curvature,
	input  logic signed [pcte_pkg::DATA_W-1:0] knot_third,
	input  logic signed [pcte_pkg::DATA_W-1:0] query_x,
	input  logic                               final_query,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [pcte_pkg::DATA_W-1:0] result_value,
	output logic                               final_result
);
	import pcte_pkg::*;

	localparam int IDX_W = $clog2(MAX_KNOTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int SUM_W = CNT_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FIRST, ST_LAST, ST_SEARCH, ST_DIFF, ST_PREP, ST_EVAL, ST_DONE
	} state_t;

	// Configuration registers.
	logic [2:0]       order_q;
	logic [CFG_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= '0;
			count_q <= CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORDER: order_q <= cfg_data[2:0];
				REG_COUNT: count_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Knot count clamped to the table, with a count of zero taken as one.
	logic [31:0]      count32;
	logic [CNT_W-1:0] n_eff;
	always_comb begin
		count32 = 32'(count_q);
		if (count32 == 32'd0) n_eff = CNT_W'(1);
		else if (count32 > 32'(MAX_KNOTS)) n_eff = CNT_W'(MAX_KNOTS);
		else n_eff = CNT_W'(count32);
	end

	state_t             state_q;
	logic [CNT_W-1:0]   n_q, lo_q, hi_q, mid_q;
	logic               up_q;
	logic [DATA_W-1:0]  first_q;
	logic signed [31:0] x_q;
	logic               final_q;
	logic signed [31:0] d_q, v_q, s_q, c_q, t_q;
	logic [63:0]        div_q;
	logic signed [31:0] res_q;
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic               out_final_q;

	logic accept, out_free, is_load, slot_ok;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign is_load  = (action == 1'b0);
	assign slot_ok  = 32'(knot_slot) < 32'(MAX_KNOTS);

	// Knot memory.
	logic [IDX_W-1:0]    raddr;
	logic [DATA_W-1:0]   rpos;
	logic [4*DATA_W-1:0] rder;

	pcte_knot_mem #(.MAX_KNOTS(MAX_KNOTS), .IDX_W(IDX_W)) u_mem (
		.clk   (clk),
		.we    (accept && is_load && slot_ok),
		.waddr (IDX_W'(knot_slot)),
		.wpos  (knot_position),
		.wder  ({knot_third, knot_curvature, knot_slope, knot_value}),
		.raddr (raddr),
		.rpos  (rpos),
		.rder  (rder)
	);

	// One bisection step. In ST_LAST the interval opens as [0, n); in ST_SEARCH the
	// position read at mid decides which half is kept.
	logic             go;
	logic [CNT_W-1:0] lo_n, hi_n, mid_n;
	logic             search_more;
	always_comb begin
		go = up_q ? ($signed(x_q) >= $signed(rpos)) : ($signed(x_q) <= $signed(rpos));
		if (state_q == ST_LAST) begin
			lo_n = '0;
			hi_n = n_q;
		end else begin
			lo_n = go ? mid_q : lo_q;
			hi_n = go ? hi_q : mid_q;
		end
		mid_n       = CNT_W'((SUM_W'(lo_n) + SUM_W'(hi_n)) >> 1);
		search_more = (mid_n != lo_n);
	end

	logic [CNT_W-1:0] n_last;
	assign n_last = n_q - CNT_W'(1);

	always_comb begin
		unique case (state_q)
			ST_IDLE:             raddr = '0;
			ST_FIRST:            raddr = n_last[IDX_W-1:0];
			ST_LAST, ST_SEARCH:  raddr = search_more ? mid_n[IDX_W-1:0] : lo_n[IDX_W-1:0];
			default:             raddr = lo_q[IDX_W-1:0];
		endcase
	end

	// Offset from the knot, and the biased operand for the rounded third/6.
	logic signed [31:0] t_rd;
	logic signed [63:0] diff;
	logic [33:0]        div_u;
	assign t_rd  = rder[4*DATA_W-1:3*DATA_W];
	assign diff  = 64'(x_q) - 64'($signed(rpos));
	assign div_u = 34'(t_rd) + 34'sd3 + DIV_BIAS;

	// Start value and coefficients of the Horner chain for each order.
	hr_ctl_t            hr_ctl;
	hr_stat_t           hr_stat;
	logic signed [31:0] acc_init, hr_res;
	coef_set_t          coef;
	logic signed [32:0] c_plus, t_plus;
	logic [31:0]        sixth;
	always_comb begin
		c_plus = 33'(c_q) + 33'sd1;
		t_plus = 33'(t_q) + 33'sd1;
		sixth  = {1'b0, div_q[63:33]} - DIV_BIAS_Q;
		hr_ctl.start = (state_q == ST_PREP);
		unique case (order_q[1:0])
			2'd0: begin
				acc_init     = sixth;
				coef         = {v_q, s_q, 32'(c_plus >>> 1)};
				hr_ctl.steps = 2'd3;
			end
			2'd1: begin
				acc_init     = 32'(t_plus >>> 1);
				coef         = {32'd0, s_q, c_q};
				hr_ctl.steps = 2'd2;
			end
			2'd2: begin
				acc_init     = t_q;
				coef         = {32'd0, 32'd0, c_q};
				hr_ctl.steps = 2'd1;
			end
			default: begin
				acc_init     = t_q;
				coef         = '0;
				hr_ctl.steps = 2'd0;
			end
		endcase
	end

	pcte_horner #(.FRACTION_BITS(FRACTION_BITS)) u_horner (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (hr_ctl),
		.d        (d_q),
		.acc_init (acc_init),
		.coef     (coef),
		.stat     (hr_stat),
		.result   (hr_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			n_q         <= '0;
			up_q        <= 1'b0;
		end else begin
			// A new result fills the output register; otherwise a taken result leaves it.
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !is_load) begin
						x_q     <= query_x;
						final_q <= final_query;
						n_q     <= n_eff;
						res_q   <= '0;
						state_q <= (order_q > 3'd3) ? ST_DONE : ST_FIRST;
					end
				end
				ST_FIRST: begin
					first_q <= rpos;
					state_q <= ST_LAST;
				end
				ST_LAST, ST_SEARCH: begin
					if (state_q == ST_LAST) up_q <= $signed(rpos) > $signed(first_q);
					lo_q    <= lo_n;
					hi_q    <= hi_n;
					mid_q   <= mid_n;
					state_q <= search_more ? ST_SEARCH : ST_DIFF;
				end
				ST_DIFF: begin
					d_q     <= sat32(diff);
					v_q     <= rder[DATA_W-1:0];
					s_q     <= rder[2*DATA_W-1:DATA_W];
					c_q     <= rder[3*DATA_W-1:2*DATA_W];
					t_q     <= t_rd;
					div_q   <= 64'(div_u[32:1]) * 64'(DIV_RECIP);
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (hr_stat.done) begin
						res_q   <= hr_res;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_value_q <= res_q;
						out_final_q <= final_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign final_result = out_final_q;

	`ASSERT_IMP(a_done_in_eval, clk, arst_n, hr_stat.done, state_q == ST_EVAL)
	`ASSERT_IMP(a_interval_open, clk, arst_n, state_q == ST_SEARCH, lo_q < hi_q && mid_q < hi_q)
	`ASSERT_NXT(a_result_shown, clk, arst_n, state_q == ST_DONE && out_free, out_valid_q)
	`ASSERT_IMP(a_knot_in_range, clk, arst_n, state_q == ST_DIFF, lo_q < n_q)
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// The testbench loads knot tables, writes the order and count registers while
// the block is idle, and sends load and query items through the valid/stall
// handshake. Each accepted query is predicted by a local copy of the knot table
// and the registers. The prediction is pushed into a queue of pending results,
// and every result that leaves the block is compared against the queue head.
module tb;
	import pcte_pkg::*;

	// Item kinds.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Derivative orders.
	localparam int ORD_VALUE = 0;
	localparam int ORD_SLOPE = 1;
	localparam int ORD_CURV  = 2;
	localparam int ORD_THIRD = 3;
	localparam int ORD_ZERO  = 4;
	localparam int ORD_TOP   = 7;

	// Shapes of a loaded knot table.
	localparam int SHAPE_UP   = 0;
	localparam int SHAPE_DOWN = 1;
	localparam int SHAPE_RAND = 2;

	localparam int KNOTS       = MAX_KNOTS_DEF;
	localparam int DRAIN_WAIT  = 40;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 125;
	localparam int HOLD_AT     = 700;
	localparam int HOLD_LEN    = 400;

	typedef struct {
		logic              act;
		logic [7:0]        slot;
		logic signed [31:0] pos, val, slope, curv, third, x;
		logic              fin;
	} knot_item_t;

	typedef struct {
		int         order;
		knot_item_t it;
		bit         typed;
		logic signed [31:0] typed_val;
	} vector_t;

	typedef struct {
		logic signed [31:0] val;
		logic               fin;
	} pending_t;

	logic clk, arst_n;
	logic cfg_we, cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid, in_stall;
	logic action, final_query;
	logic [7:0] knot_slot;
	logic signed [31:0] knot_position, knot_value, knot_slope, knot_curvature;
	logic signed [31:0] knot_third, query_x;
	logic out_valid, out_stall;
	logic signed [31:0] result_value;
	logic final_result;

	// Local copy of the block's state.
	logic signed [31:0] pos_tab [KNOTS];
	logic signed [31:0] val_tab [KNOTS];
	logic signed [31:0] slope_tab [KNOTS];
	logic signed [31:0] curv_tab [KNOTS];
	logic signed [31:0] third_tab [KNOTS];
	int cur_order, cur_count;

	pending_t pending_results [$];
	int errors;
	int tx_idle, rx_idle;
	int rand_done;
	int cycles;
	logic hold_out;

	piecewise_cubic_taylor_eval i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .knot_slot(knot_slot), .knot_position(knot_position),
		.knot_value(knot_value), .knot_slope(knot_slope),
		.knot_curvature(knot_curvature), .knot_third(knot_third),
		.query_x(query_x), .final_query(final_query),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .final_result(final_result)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Fixed point helpers, all in 64-bit signed arithmetic.
	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic signed [63:0] div_floor(input logic signed [63:0] a,
			input logic signed [63:0] dv);
		logic signed [63:0] q;
		q = a / dv;
		if ((a % dv) != 0 && a < 0) q = q - 1;
		return q;
	endfunction

	// One Horner stage: the product is rounded half up to 16 fraction bits,
	// then the sum saturates.
	function automatic logic signed [63:0] horner_step(input logic signed [63:0] c,
			input logic signed [63:0] d, input logic signed [63:0] acc);
		logic signed [63:0] p;
		p = d * acc;
		return clamp32(c + ((p + 64'sd32768) >>> 16));
	endfunction

	// Bisection over the first n knots; the direction follows the two end knots.
	function automatic int locate_knot(input logic signed [31:0] x, input int n);
		int lo, hi, mid;
		bit up, go;
		lo = 0;
		hi = n;
		up = pos_tab[n-1] > pos_tab[0];
		mid = (lo + hi) >> 1;
		while (mid != lo) begin
			go = up ? (x >= pos_tab[mid]) : (x <= pos_tab[mid]);
			if (go) lo = mid; else hi = mid;
			mid = (lo + hi) >> 1;
		end
		return lo;
	endfunction

	function automatic logic signed [31:0] taylor_result(input logic signed [31:0] x);
		int n, k;
		logic signed [63:0] d, v, s, c, t, acc, xw, pw;
		if (cur_order > ORD_THIRD) return 32'sd0;
		n = cur_count;
		if (n < 1) n = 1;
		if (n > KNOTS) n = KNOTS;
		k = locate_knot(x, n);
		xw = x;
		pw = pos_tab[k];
		d = clamp32(xw - pw);
		v = val_tab[k];
		s = slope_tab[k];
		c = curv_tab[k];
		t = third_tab[k];
		case (cur_order)
			ORD_VALUE: begin
				acc = div_floor(2 * t + 6, 12);
				acc = horner_step(div_floor(c + 1, 2), d, acc);
				acc = horner_step(s, d, acc);
				acc = horner_step(v, d, acc);
			end
			ORD_SLOPE: begin
				acc = div_floor(t + 1, 2);
				acc = horner_step(c, d, acc);
				acc = horner_step(s, d, acc);
			end
			ORD_CURV: acc = horner_step(c, d, t);
			default: acc = t;
		endcase
		return acc[31:0];
	endfunction

	function automatic knot_item_t mk_item(input logic act, input logic [7:0] slot,
			input logic signed [31:0] pos, val, slope, curv, third, x,
			input logic fin);
		knot_item_t it;
		it.act = act; it.slot = slot; it.pos = pos; it.val = val;
		it.slope = slope; it.curv = curv; it.third = third; it.x = x; it.fin = fin;
		return it;
	endfunction

	function automatic vector_t mk_vec(input int order, input knot_item_t it,
			input bit typed, input logic signed [31:0] tv);
		vector_t r;
		r.order = order; r.it = it; r.typed = typed; r.typed_val = tv;
		return r;
	endfunction

	// Mostly moderate coefficients so that results stay away from the rails,
	// with full range and extreme codes now and then.
	function automatic logic signed [31:0] rand_coef();
		case ($urandom_range(7))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
		endcase
	endfunction

	// Sends one item, with random gaps ahead of it. The predictor is updated at
	// the edge that accepts the item, so loads and queries stay in order.
	task automatic send_item(input knot_item_t it, input bit typed,
			input logic signed [31:0] tv);
		pending_t e;
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.act;
		knot_slot <= it.slot;
		knot_position <= it.pos;
		knot_value <= it.val;
		knot_slope <= it.slope;
		knot_curvature <= it.curv;
		knot_third <= it.third;
		query_x <= it.x;
		final_query <= it.fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (it.act == ACT_LOAD) begin
			pos_tab[it.slot] = it.pos;
			val_tab[it.slot] = it.val;
			slope_tab[it.slot] = it.slope;
			curv_tab[it.slot] = it.curv;
			third_tab[it.slot] = it.third;
		end else begin
			e.val = typed ? tv : taylor_result(it.x);
			e.fin = it.fin;
			pending_results.push_back(e);
		end
	endtask

	// Stops offering items and waits until the block has gone quiet. Loads give
	// no result, so a fixed tail covers work still in flight.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ORDER) cur_order = value & 7;
		else cur_count = value & 9'h1FF;
	endtask

	// Loads the first n slots with a monotonic or scrambled table.
	task automatic load_table(input int n, input int shape);
		logic signed [63:0] step, base, p;
		step = $urandom_range(32'h0080_0000, 1);
		base = -(n * step) / 2;
		for (int i = 0; i < n; i++) begin
			case (shape)
				SHAPE_UP:   p = base + i * step;
				SHAPE_DOWN: p = -(base + i * step);
				default:    p = $signed($urandom);
			endcase
			send_item(mk_item(ACT_LOAD, i[7:0], p[31:0], rand_coef(), rand_coef(),
				rand_coef(), rand_coef(), 32'sd0, 1'b0), 1'b0, 32'sd0);
		end
	endtask

	function automatic knot_item_t rand_item(input int n);
		int k;
		logic signed [31:0] x;
		if ($urandom_range(99) < 12) begin
			// Rewrites may break the order of the table; the search must cope.
			k = ($urandom_range(3) == 0) ? $urandom_range(KNOTS - 1) : $urandom_range(n - 1);
			return mk_item(ACT_LOAD, k[7:0], $signed($urandom), rand_coef(), rand_coef(),
				rand_coef(), rand_coef(), $signed($urandom), 1'($urandom_range(1)));
		end
		case ($urandom_range(9))
			0, 1: x = $signed($urandom);
			2: x = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: begin
				k = $urandom_range(n - 1);
				x = pos_tab[k] + ($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
			end
		endcase
		return mk_item(ACT_QUERY, 8'($urandom), $signed($urandom), $signed($urandom),
			$signed($urandom), $signed($urandom), $signed($urandom), x,
			1'($urandom_range(1)));
	endfunction

	// Receiver: random stalls, plus one long hold-off so the block backs up.
	always @(posedge clk) out_stall <= hold_out || ($urandom_range(99) < rx_idle);

	initial begin
		hold_out = 1'b0;
		wait (rand_done >= HOLD_AT);
		@(posedge clk);
		hold_out <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		hold_out <= 1'b0;
	end

	// Result checker: every result must match the oldest prediction.
	always @(posedge clk) begin
		pending_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no pending query: result_value %h", result_value);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (result_value !== e.val) begin
					$error("result_value expected %h actual %h", e.val, result_value);
					errors++;
				end
				if (final_result !== e.fin) begin
					$error("final_result expected %b actual %b", e.fin, final_result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		vector_t vecs [$];
		int orders [PHASES];
		int counts [PHASES];
		int shapes [PHASES];
		int n;

		cycles = 0;
		errors = 0;
		rand_done = 0;
		tx_idle = 20;
		rx_idle = 88;
		cur_order = ORD_VALUE;
		cur_count = 1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ORDER;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_LOAD;
		knot_slot = '0;
		knot_position = '0;
		knot_value = '0;
		knot_slope = '0;
		knot_curvature = '0;
		knot_third = '0;
		query_x = '0;
		final_query = 1'b0;
		out_stall = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The count stays at its reset value of one, so only
		// slot 0 is ever searched. Typed expectations are the obvious ones:
		// a query right on the knot gives its value, the third-derivative
		// order gives the stored third, and high orders give zero.
		vecs.push_back(mk_vec(ORD_VALUE, mk_item(ACT_LOAD, 8'd0, 32'sd0, 32'sh7FFFFFFF,
			32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0), 1'b0, 32'sd0));
		vecs.push_back(mk_vec(ORD_VALUE, mk_item(ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sd0, 1'b1), 1'b1, 32'sh7FFFFFFF));
		vecs.push_back(mk_vec(ORD_VALUE, mk_item(ACT_QUERY, 8'hFF, -32'sd1, -32'sd1,
			-32'sd1, -32'sd1, -32'sd1, 32'sh7FFFFFFF, 1'b0), 1'b0, 32'sd0));
		vecs.push_back(mk_vec(ORD_VALUE, mk_item(ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sh80000000, 1'b1), 1'b0, 32'sd0));
		vecs.push_back(mk_vec(ORD_VALUE, mk_item(ACT_LOAD, 8'd0, 32'sh80000000,
			32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd0, 1'b1),
			1'b0, 32'sd0));
		vecs.push_back(mk_vec(ORD_VALUE, mk_item(ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sh80000000, 1'b0), 1'b1, 32'sh80000000));
		// Distance saturates here: the query sits at the far end from the knot.
		vecs.push_back(mk_vec(ORD_VALUE, mk_item(ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sh7FFFFFFF, 1'b1), 1'b0, 32'sd0));
		vecs.push_back(mk_vec(ORD_SLOPE, mk_item(ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sd0, 1'b0), 1'b0, 32'sd0));
		vecs.push_back(mk_vec(ORD_CURV, mk_item(ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sh7FFFFFFF, 1'b1), 1'b0, 32'sd0));
		vecs.push_back(mk_vec(ORD_THIRD, mk_item(ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sd12345, 1'b0), 1'b1, 32'sh7FFFFFFF));
		vecs.push_back(mk_vec(ORD_ZERO, mk_item(ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sd7, 1'b1), 1'b1, 32'sd0));
		vecs.push_back(mk_vec(ORD_TOP, mk_item(ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sh80000000, 1'b0), 1'b1, 32'sd0));
		// The top slot may be written even though the search never reaches it.
		vecs.push_back(mk_vec(ORD_TOP, mk_item(ACT_LOAD, 8'hFF, -32'sd1, -32'sd1, -32'sd1,
			-32'sd1, -32'sd1, -32'sd1, 1'b1), 1'b0, 32'sd0));
		vecs.push_back(mk_vec(ORD_VALUE, mk_item(ACT_LOAD, 8'd0, 32'sh0001_8000,
			-32'sh0002_0000, 32'sh0000_C000, -32'sd3, -32'sd1, 32'sd0, 1'b0), 1'b0, 32'sd0));
		for (int o = ORD_VALUE; o <= ORD_THIRD; o++) begin
			vecs.push_back(mk_vec(o, mk_item(ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
				32'sd0, -32'sh0003_4567, 1'b0), 1'b0, 32'sd0));
			vecs.push_back(mk_vec(o, mk_item(ACT_QUERY, 8'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
				32'sd0, 32'sh0005_0001, 1'b1), 1'b0, 32'sd0));
		end
		foreach (vecs[i]) begin
			if (vecs[i].order != cur_order) write_reg(REG_ORDER, vecs[i].order);
			send_item(vecs[i].it, vecs[i].typed, vecs[i].typed_val);
		end

		// Random part. The first phase fills the whole table, so no later
		// query can read a slot that was never written.
		orders = '{ORD_VALUE, ORD_SLOPE, ORD_CURV, ORD_THIRD, 5, ORD_VALUE, ORD_VALUE,
			ORD_VALUE};
		counts = '{KNOTS, 2, 3, 17, KNOTS, 0, 511, 0};
		shapes = '{SHAPE_UP, SHAPE_DOWN, SHAPE_UP, SHAPE_RAND, SHAPE_UP, SHAPE_DOWN,
			SHAPE_DOWN, SHAPE_UP};
		orders[PHASES-1] = $urandom_range(ORD_THIRD);
		counts[PHASES-1] = $urandom_range(KNOTS, 1);
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_ORDER, orders[p]);
			write_reg(REG_COUNT, counts[p]);
			n = counts[p];
			if (n < 1) n = 1;
			if (n > KNOTS) n = KNOTS;
			load_table(n, shapes[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Sender busy and receiver slow first, then the reverse, then
				// both sides at full rate.
				if (rand_done < 330) begin
					tx_idle = 20; rx_idle = 88;
				end else if (rand_done < 660) begin
					tx_idle = 88; rx_idle = 20;
				end else begin
					tx_idle = 0; rx_idle = 0;
				end
				send_item(rand_item(n), 1'b0, 32'sd0);
				rand_done++;
			end
		end

		drain();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
